// ===== rtl/tfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_pkg
// Shared types and constants of the telemetry frame encoder.
// ----------------------------------------------------------------------------
package tfe_pkg;

	localparam int unsigned CountW  = 7;
	localparam int unsigned QDepth  = 2;
	localparam int unsigned QPtrW   = $clog2(QDepth);
	localparam int unsigned QCntW   = $clog2(QDepth + 1);

	localparam logic [7:0] HdrByte0 = 8'hAA;
	localparam logic [7:0] HdrByte1 = 8'hFF;
	localparam logic [7:0] HdrByte2 = 8'hF1;

	// one classified value, as handed from the front to the back
	typedef struct packed {
		logic       first;
		logic       last;
		logic [7:0] len_byte;
		logic [7:0] lo_byte;
		logic [7:0] hi_byte;
		logic [7:0] byte_sum;
		logic [7:0] sum_of_sums;
	} tfe_entry_t;

endpackage

// ===== rtl/tfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_front
// Accepts values, tracks frame position and checksums, classifies each value.
// ----------------------------------------------------------------------------
module tfe_front import tfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CountW-1:0]    element_count,
	input  logic                 accept,
	input  logic signed [15:0]   sample_value,
	output tfe_entry_t           entry
);

	logic [CountW-1:0] values_sent_q;
	logic [7:0]        byte_sum_q;
	logic [7:0]        sum_of_sums_q;

	logic [CountW-1:0] count;
	logic [CountW-1:0] values_sent_n;
	logic [7:0]        lo_byte;
	logic [7:0]        hi_byte;
	logic [7:0]        byte_sum_n;
	logic [7:0]        sum_of_sums_n;
	logic              last;

	always_comb begin
		count         = (element_count == '0) ? CountW'(1) : element_count;
		lo_byte       = sample_value[7:0];
		hi_byte       = sample_value[15:8];
		byte_sum_n    = byte_sum_q + lo_byte + hi_byte;
		sum_of_sums_n = sum_of_sums_q + byte_sum_n;
		values_sent_n = values_sent_q + CountW'(1);
		last          = (values_sent_n == '0) || (values_sent_n >= count);

		entry.first       = (values_sent_q == '0);
		entry.last        = last;
		entry.len_byte    = {count, 1'b0};
		entry.lo_byte     = lo_byte;
		entry.hi_byte     = hi_byte;
		entry.byte_sum    = byte_sum_n;
		entry.sum_of_sums = sum_of_sums_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			values_sent_q <= '0;
			byte_sum_q    <= '0;
			sum_of_sums_q <= '0;
		end else if (accept) begin
			if (last) begin
				values_sent_q <= '0;
				byte_sum_q    <= '0;
				sum_of_sums_q <= '0;
			end else begin
				values_sent_q <= values_sent_n;
				byte_sum_q    <= byte_sum_n;
				sum_of_sums_q <= sum_of_sums_n;
			end
		end
	end

endmodule

// ===== rtl/tfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module tfe_queue import tfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tfe_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output tfe_entry_t head_entry
);

	tfe_entry_t         slots_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QCntW-1:0]   fill_q;

	assign full       = (fill_q == QCntW'(QDepth));
	assign head_valid = (fill_q != '0);
	assign head_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QCntW'(1);
				2'b01:   fill_q <= fill_q - QCntW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/tfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_back
// Byte sequencer: turns each queued entry into frame bytes, one a beat unless stalled.
// ----------------------------------------------------------------------------
module tfe_back import tfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  tfe_entry_t head_entry,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       frame_end
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_HDR2,
		PH_LEN,
		PH_LO,
		PH_HI,
		PH_SUM,
		PH_SOS
	} phase_t;

	phase_t     phase_q;
	logic       fresh_q;
	logic       out_valid_q;
	logic [7:0] frame_byte_q;
	logic       frame_end_q;

	phase_t     cur_ph;
	phase_t     next_ph;
	logic       advance;
	logic       emit;
	logic       done;
	logic [7:0] sel_byte;

	assign advance = !out_valid_q || !out_stall;
	assign emit    = advance && head_valid;
	assign pop     = emit && done;

	always_comb begin
		cur_ph = fresh_q ? (head_entry.first ? PH_HDR0 : PH_LO) : phase_q;
		next_ph  = cur_ph;
		done     = 1'b0;
		sel_byte = head_entry.lo_byte;
		unique case (cur_ph)
			PH_HDR0: begin
				sel_byte = HdrByte0;
				next_ph  = PH_HDR1;
			end
			PH_HDR1: begin
				sel_byte = HdrByte1;
				next_ph  = PH_HDR2;
			end
			PH_HDR2: begin
				sel_byte = HdrByte2;
				next_ph  = PH_LEN;
			end
			PH_LEN: begin
				sel_byte = head_entry.len_byte;
				next_ph  = PH_LO;
			end
			PH_LO: begin
				sel_byte = head_entry.lo_byte;
				next_ph  = PH_HI;
			end
			PH_HI: begin
				sel_byte = head_entry.hi_byte;
				next_ph  = PH_SUM;
				done     = !head_entry.last;
			end
			PH_SUM: begin
				sel_byte = head_entry.byte_sum;
				next_ph  = PH_SOS;
			end
			PH_SOS: begin
				sel_byte = head_entry.sum_of_sums;
				next_ph  = PH_HDR0;
				done     = 1'b1;
			end
			default: begin
				sel_byte = head_entry.lo_byte;
				next_ph  = PH_HDR0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			fresh_q      <= 1'b1;
			out_valid_q  <= 1'b0;
			frame_byte_q <= '0;
			frame_end_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				frame_byte_q <= sel_byte;
				frame_end_q  <= (cur_ph == PH_SOS);
				phase_q      <= next_ph;
				fresh_q      <= done;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign frame_end  = frame_end_q;

endmodule

// ===== rtl/telemetry_frame_encoder.sv =====
`timescale 1ns / 1ps
// path: an accepted value enters a queue slot; its bytes leave via a register
// throughput: one output byte a cycle when not stalled and an entry is queued;
// a value is 2 bytes, 6 if first in a frame, 2 more if last, set by tfe_back
// the front takes a value a cycle while the two-entry queue has room
// reset: arst_n clears frame position, checksums and queue; element_count = 1
// ----------------------------------------------------------------------------
// telemetry_frame_encoder
// Byte-serial frame encoder with header, length and two running checksums.
// ----------------------------------------------------------------------------
module telemetry_frame_encoder import tfe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CountW-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  sample_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          frame_byte,
	output logic                frame_end
);

	logic [CountW-1:0] element_count_q;
	logic              accept;
	logic              q_full;
	logic              q_pop;
	logic              head_valid;
	tfe_entry_t        push_entry;
	tfe_entry_t        head_entry;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= CountW'(1);
		end else if (cfg_valid && cfg_ready) begin
			element_count_q <= cfg_data;
		end
	end

	tfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.element_count (element_count_q),
		.accept        (accept),
		.sample_value  (sample_value),
		.entry         (push_entry)
	);

	tfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	tfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

endmodule
